// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the rasterizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- hdl/tpc_pkg.sv -----
// Package with shared types and constants of the triangle rasterizer.
package tpc_pkg;
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLOUR   = 2'd3;
	localparam logic OP_SHADE = 1'b0;
	localparam logic OP_CLEAR = 1'b1;
	localparam logic [15:0] FAR_DEPTH = 16'hFFFF;

	// One-hot controller states.
	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_EDGE  = 10'b0000000010,
		ST_COV   = 10'b0000000100,
		ST_MUL   = 10'b0000001000,
		ST_SUM   = 10'b0000010000,
		ST_DIV   = 10'b0000100000,
		ST_RD    = 10'b0001000000,
		ST_WR    = 10'b0010000000,
		ST_CLR   = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic load;      // capture input beat
		logic edge_ev;   // evaluate edges for the sample selected by sample
		logic [1:0] sample;
		logic mul;       // depth products
		logic sum;       // sum and sign handling
		logic div_start;
		logic div_step;
		logic rd;        // depth store read
		logic wr;        // depth store update
		logic clr;       // clear entry
		logic out_load;  // load result register
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic op;
		logic div_done;
	} sts_t;
endpackage

// ----- hdl/tpc_ram.sv -----
// Generic single-port RAM with registered read.
module tpc_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ----- hdl/tpc_ctrl.sv -----
// Controller state machine of the triangle rasterizer.
module tpc_ctrl import tpc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic out_busy,
	input  logic clearing,
	input  sts_t sts,
	output logic in_ready,
	output cmd_t cmd
);
`include "assert_macros.svh"
	state_t state_q;
	logic [1:0] smp_q;

	assign in_ready = state_q == ST_IDLE && !clearing;

	always_comb begin
		cmd = '0;
		cmd.load = in_fire;
		cmd.sample = smp_q;
		case (state_q)
			ST_EDGE: cmd.edge_ev = 1'b1;
			ST_MUL:  cmd.mul = 1'b1;
			ST_SUM:  begin cmd.sum = 1'b1; cmd.div_start = 1'b1; end
			ST_DIV:  cmd.div_step = 1'b1;
			ST_RD:   cmd.rd = 1'b1;
			ST_WR:   cmd.wr = 1'b1;
			ST_CLR:  cmd.clr = 1'b1;
			ST_OUT:  cmd.out_load = !out_busy;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			smp_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_fire) begin
					state_q <= ST_EDGE;
					smp_q <= '0;
				end
				ST_EDGE: begin
					if (sts.op == OP_CLEAR) state_q <= ST_CLR;
					else if (smp_q == 2'd3) state_q <= ST_COV;
					smp_q <= smp_q + 2'd1;
				end
				ST_COV:  state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_DIV;
				ST_DIV:  if (sts.div_done) state_q <= ST_RD;
				ST_RD:   state_q <= ST_WR;
				ST_WR:   state_q <= ST_OUT;
				ST_CLR:  state_q <= ST_OUT;
				ST_OUT:  if (!out_busy) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_IMPL(a_onehot, clk, arst_n, 1'b1, $onehot(state_q))
	`ASSERT_NEXT(a_fire_edge, clk, arst_n, in_fire, state_q == ST_EDGE)
	`ASSERT_IMPL(a_wr_clr, clk, arst_n, cmd.wr, !cmd.clr)
endmodule

// ----- hdl/tpc_dp.sv -----
// Datapath of the triangle rasterizer: edges, depth, store and result.
module tpc_dp import tpc_pkg::*; #(
	parameter int unsigned SCREEN_WIDTH = 256,
	parameter int unsigned SCREEN_HEIGHT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [16:0] in_data,
	input  logic [43:0] va,
	input  logic [43:0] vb,
	input  logic [43:0] vc,
	input  logic [23:0] colour,
	input  logic        clear_we,
	input  logic [15:0] clear_addr,
	input  logic        out_take,
	output logic        out_valid,
	output logic [63:0] out_data
);
	localparam int unsigned IDX_W = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT) + 1;

	logic op_q;
	logic [7:0] x_q, y_q;
	logic [15:0] idx_q;
	logic [2:0] cov_q;
	logic signed [14:0] vx [3], vy [3];
	logic [15:0] vz [3];
	logic signed [14:0] px, py;
	logic [IDX_W+7:0] idx_full;

	assign vx[0] = {1'b0, va[43:30]};
	assign vx[1] = {1'b0, vb[43:30]};
	assign vx[2] = {1'b0, vc[43:30]};
	assign vy[0] = {1'b0, va[29:16]};
	assign vy[1] = {1'b0, vb[29:16]};
	assign vy[2] = {1'b0, vc[29:16]};
	assign vz[0] = va[15:0];
	assign vz[1] = vb[15:0];
	assign vz[2] = vc[15:0];
	assign px = {3'b0, x_q, 4'b0};
	assign py = {3'b0, y_q, 4'b0};

	// Pixel index in wrapping arithmetic.
	assign idx_full = (IDX_W+8)'((SCREEN_HEIGHT - 1) * SCREEN_WIDTH)
		- (IDX_W+8)'(in_data[16:9]) * (IDX_W+8)'(SCREEN_WIDTH)
		+ (IDX_W+8)'(in_data[8:1]);

	// Edge evaluation for one sample point per cycle.
	logic signed [14:0] sx, sy;
	logic signed [31:0] ev [3];
	logic covered;
	always_comb begin
		case (cmd.sample)
			2'd0: begin sx = px - 15'sd4;  sy = py; end
			2'd1: begin sx = px - 15'sd4;  sy = py - 15'sd4; end
			2'd2: begin sx = px - 15'sd12; sy = py - 15'sd4; end
			default: begin sx = px - 15'sd12; sy = py - 15'sd12; end
		endcase
		for (int e = 0; e < 3; e++) begin
			ev[e] = 32'(vx[e] - vx[(e+1)%3]) * 32'(vy[e] - sy)
				- 32'(vy[e] - vy[(e+1)%3]) * 32'(vx[e] - sx);
		end
		covered = (ev[0] > 0 && ev[1] > 0 && ev[2] > 0)
			|| (ev[0] < 0 && ev[1] < 0 && ev[2] < 0);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_data[0];
			x_q <= in_data[8:1];
			y_q <= in_data[16:9];
			idx_q <= idx_full[15:0];
			cov_q <= '0;
		end else if (cmd.edge_ev && covered) begin
			cov_q <= cov_q + 3'd1;
		end
	end

	// Barycentric numerators (edge values at the pixel) and area.
	logic signed [31:0] n_s1 [3];
	logic signed [31:0] den_s1;
	always_ff @(posedge clk) begin
		for (int e = 0; e < 3; e++) begin
			n_s1[e] <= 32'(vx[(e+1)%3] - px) * 32'(vy[(e+2)%3] - py)
				- 32'(vx[(e+2)%3] - px) * 32'(vy[(e+1)%3] - py);
		end
		den_s1 <= 32'(vx[1] - vx[0]) * 32'(vy[2] - vy[0])
			- 32'(vx[2] - vx[0]) * 32'(vy[1] - vy[0]);
	end

	logic signed [48:0] prod_s2 [3];
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			for (int e = 0; e < 3; e++) begin
				prod_s2[e] <= 49'(n_s1[e]) * $signed({33'b0, vz[e]});
			end
		end
	end

	// Sum, sign fold, then restoring division (one quotient bit a cycle).
	logic signed [50:0] num;
	logic signed [31:0] den_pos;
	assign num = 51'(prod_s2[0]) + 51'(prod_s2[1]) + 51'(prod_s2[2]);
	assign den_pos = den_s1[31] ? -den_s1 : den_s1;

	logic [50:0] rem_q, quo_q;
	logic [31:0] dv_q;
	logic [5:0] cnt_q;
	logic zero_q, neg_q;
	logic [15:0] depth_q;
	logic [50:0] rem_sh;
	logic [51:0] trial;
	always_comb begin
		rem_sh = {rem_q[49:0], quo_q[50]};
		trial = {1'b0, rem_sh} - {20'b0, dv_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= 6'd51;
		end else if (cmd.div_step && cnt_q != 0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= den_s1[31] ? 51'(-num) : 51'(num);
			dv_q <= den_pos;
			zero_q <= den_s1 == 0;
			neg_q <= den_s1[31] ? (num > 0) : (num < 0);
		end else if (cmd.div_step && cnt_q != 0) begin
			if (!trial[51]) begin
				rem_q <= trial[50:0];
				quo_q <= {quo_q[49:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[49:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (zero_q) depth_q = FAR_DEPTH;
		else if (neg_q) depth_q = '0;
		else if (quo_q[50:16] != 0) depth_q = FAR_DEPTH;
		else depth_q = quo_q[15:0];
	end

	assign sts.op = op_q;
	assign sts.div_done = cnt_q == 0;

	// Depth store access.
	logic [15:0] stored;
	logic ram_we, pass;
	logic [15:0] ram_wd, ram_addr;
	assign pass = cov_q != 0 && stored > depth_q;
	always_comb begin
		ram_we = clear_we | cmd.clr | (cmd.wr && cov_q != 0);
		ram_addr = clear_we ? clear_addr : idx_q;
		if (clear_we || cmd.clr || cov_q != 3'd4) ram_wd = FAR_DEPTH;
		else ram_wd = pass ? depth_q : stored;
	end

	tpc_ram #(.WIDTH(16), .DEPTH(65536)) u_store (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(stored)
	);

	logic wr_q;
	always_ff @(posedge clk) begin
		if (cmd.wr) wr_q <= pass;
		else if (cmd.clr) wr_q <= 1'b0;
	end

	// Result register.
	logic [7:0] r_s, g_s, b_s;
	logic [15:0] d_s;
	always_comb begin
		r_s = 8'((10'(colour[23:16]) * 10'(cov_q)) >> 2);
		g_s = 8'((10'(colour[15:8]) * 10'(cov_q)) >> 2);
		b_s = 8'((10'(colour[7:0]) * 10'(cov_q)) >> 2);
		d_s = (op_q == OP_CLEAR || cov_q == 0) ? 16'd0 : depth_q;
		if (!wr_q || op_q == OP_CLEAR) begin r_s = '0; g_s = '0; b_s = '0; end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_take) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data <= {4'b0, b_s, g_s, r_s, d_s,
				(op_q == OP_CLEAR) ? 3'd0 : cov_q, idx_q,
				wr_q & (op_q == OP_SHADE)};
		end
	end
endmodule

// ----- hdl/triangle_pixel_coverage_depth_test_top.sv -----
// A shade beat passes from its accepting edge to m_tvalid through the sample edge tests,
// depth products, the restoring divider, store read and write and result load; a clear beat
// through an edge state, a store clear and result load. A new beat is taken only once the
// controller is back in idle after the result load; output stalls delay this.
// After reset a clearing pass writes farthest depth to all 65536 store entries, one per
// cycle, before the first input beat is taken; setup registers reset to zero.
module triangle_pixel_coverage_depth_test_top import tpc_pkg::*; #(
	parameter int unsigned SCREEN_WIDTH = 256,
	parameter int unsigned SCREEN_HEIGHT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // op, pixel_x, pixel_y, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // write_pixel, index, coverage, depth, r, g, b, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [43:0] cfg_data
);
`include "assert_macros.svh"
	logic [43:0] va_q, vb_q, vc_q;
	logic [23:0] col_q;
	logic [16:0] clr_cnt_q;
	logic clearing;
	logic in_ready;
	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;
	// Configuration writes land in the setup registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q <= '0; vb_q <= '0; vc_q <= '0; col_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_VERTEX_A: va_q <= cfg_data;
				REG_VERTEX_B: vb_q <= cfg_data;
				REG_VERTEX_C: vc_q <= cfg_data;
				REG_COLOUR:   col_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// The clearing pass counts through the store after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_cnt_q <= '0;
		else if (clearing) clr_cnt_q <= clr_cnt_q + 17'd1;
	end
	assign clearing = !clr_cnt_q[16];

	assign s_tready = in_ready;

	tpc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(s_tvalid && s_tready),
		.out_busy(m_tvalid && !m_tready), .clearing(clearing),
		.sts(sts), .in_ready(in_ready), .cmd(cmd)
	);

	tpc_dp #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_data(s_tdata[16:0]), .va(va_q), .vb(vb_q), .vc(vc_q), .colour(col_q),
		.clear_we(clearing), .clear_addr(clr_cnt_q[15:0]),
		.out_take(m_tready), .out_valid(m_tvalid), .out_data(m_tdata)
	);

	`ASSERT_IMPL(a_no_in_clearing, clk, arst_n, clearing, !s_tready)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`ASSERT_IMPL(a_ready_busy, clk, arst_n, m_tvalid && !m_tready, 1'b1)
endmodule
